[sv/dpht_pkg.sv]
// Shared types and constants for the depth-preferred hash table.
package dpht_pkg;

	localparam int TABLE_ENTRIES = 65536;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = 32;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_LOOKUP = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [63:0] key;
		logic [31:0] score;
		logic [7:0]  depth;
		logic [1:0]  kind;
		logic [15:0] move;
	} entry_t;

	// write request into the table memory
	typedef struct packed {
		logic   we;
		idx_t   addr;
		entry_t data;
	} ram_wr_t;

endpackage

[sv/dpht_ram.sv]
// Table memory: one write port, one registered read port.
module dpht_ram (
	input  logic              clk,
	input  dpht_pkg::ram_wr_t wr,
	input  logic              rd_en,
	input  dpht_pkg::idx_t    rd_addr,
	output dpht_pkg::entry_t  rd_data
);

	dpht_pkg::entry_t mem [dpht_pkg::TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/depth_preferred_hash_table_core.sv]
// Top level: direct-mapped hash table with depth-preferred replacement.
// Insert, lookup and the unused command: slot read at the accepting edge, then ST_EVAL
//   decides, writes back and pulses done; busy keeps a new word out until then, a limit
//   set by the read-then-write of the single table memory.
// Clear: the memory is swept one entry per cycle, busy high throughout, done on the last write.
// Reset: the same sweep of all TABLE_ENTRIES entries runs with busy high; counter cleared at once.
// done is a one-cycle strobe; the receiver cannot stall and results are never held back.
module depth_preferred_hash_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [63:0] key,
	input  logic [31:0] score,
	input  logic [7:0]  search_depth,
	input  logic [1:0]  bound_kind,
	input  logic [15:0] best_move,
	output logic        done,
	output logic [63:0] found_key,
	output logic        occupied,
	output logic [31:0] score_out,
	output logic [7:0]  depth_out,
	output logic [1:0]  kind_out,
	output logic [15:0] move_out,
	output logic        was_replaced,
	output logic [31:0] replace_total
);

	typedef enum logic [1:0] {
		ST_INIT,	// post-reset wipe
		ST_IDLE,
		ST_EVAL,	// read data back, decide, write back
		ST_CLEAR	// clear command wipe
	} state_t;

	state_t            state_q;
	dpht_pkg::idx_t    sweep_q;
	dpht_pkg::cnt_t    cnt_q;

	// captured input word
	logic [1:0]        cmd_q;
	dpht_pkg::entry_t  new_q;

	logic              accept;
	dpht_pkg::ram_wr_t ram_wr;
	dpht_pkg::entry_t  rd_entry;
	dpht_pkg::entry_t  post;
	logic              take;
	logic              take_ins;
	logic              report_en;
	logic              post_occ;
	dpht_pkg::cnt_t    cnt_next;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	dpht_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (accept),
		.rd_addr (key[dpht_pkg::IDX_W-1:0]),
		.rd_data (rd_entry)
	);

	// Replacement rule: empty slot, other key, deeper search, or same depth
	// with a stronger bound.
	always_comb begin
		take = (rd_entry.key == 64'd0) || (rd_entry.key != new_q.key) ||
			(rd_entry.depth < new_q.depth) ||
			((rd_entry.depth == new_q.depth) && (rd_entry.kind < new_q.kind));
		take_ins  = (cmd_q == dpht_pkg::CMD_INSERT) && take;
		report_en = (cmd_q == dpht_pkg::CMD_INSERT) || (cmd_q == dpht_pkg::CMD_LOOKUP);
		post      = take_ins ? new_q : rd_entry;
		post_occ  = report_en && (post.key != 64'd0);
		cnt_next  = (take_ins && (cnt_q != '1)) ? cnt_q + dpht_pkg::cnt_t'(1) : cnt_q;
	end

	// Memory writes: zero fill during a sweep, entry write-back on a taken insert.
	always_comb begin
		ram_wr = '0;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = sweep_q;
		end else if (state_q == ST_EVAL && take_ins) begin
			ram_wr.we   = 1'b1;
			ram_wr.addr = new_q.key[dpht_pkg::IDX_W-1:0];
			ram_wr.data = new_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			sweep_q       <= '0;
			cnt_q         <= '0;
			cmd_q         <= dpht_pkg::CMD_INSERT;
			new_q         <= '0;
			done          <= 1'b0;
			found_key     <= '0;
			occupied      <= 1'b0;
			score_out     <= '0;
			depth_out     <= '0;
			kind_out      <= '0;
			move_out      <= '0;
			was_replaced  <= 1'b0;
			replace_total <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + dpht_pkg::idx_t'(1);
					if (sweep_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q       <= command;
						new_q.key   <= key;
						new_q.score <= score;
						new_q.depth <= search_depth;
						new_q.kind  <= bound_kind;
						new_q.move  <= best_move;
						sweep_q     <= '0;
						state_q     <= (command == dpht_pkg::CMD_CLEAR) ? ST_CLEAR : ST_EVAL;
					end
				end
				ST_EVAL: begin
					// an empty slot, and the unused command, report zero entry fields; the counter is still reported
					done          <= 1'b1;
					occupied      <= post_occ;
					found_key     <= post_occ ? post.key   : 64'd0;
					score_out     <= post_occ ? post.score : 32'd0;
					depth_out     <= post_occ ? post.depth : 8'd0;
					kind_out      <= post_occ ? post.kind  : 2'd0;
					move_out      <= post_occ ? post.move  : 16'd0;
					was_replaced  <= take_ins;
					replace_total <= cnt_next;
					cnt_q         <= cnt_next;
					state_q       <= ST_IDLE;
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + dpht_pkg::idx_t'(1);
					if (sweep_q == '1) begin
						done          <= 1'b1;
						cnt_q         <= '0;
						occupied      <= 1'b0;
						found_key     <= '0;
						score_out     <= '0;
						depth_out     <= '0;
						kind_out      <= '0;
						move_out      <= '0;
						was_replaced  <= 1'b0;
						replace_total <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// result only follows an evaluation or the last cycle of a clear sweep
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_CLEAR))
		else $error("done without a finished command");

	// table is only written while busy
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.we |-> busy)
		else $error("table write while idle");

	// a clear result reports an empty counter
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(state_q) == ST_CLEAR) |-> (replace_total == '0 && cnt_q == '0))
		else $error("clear left the counter set");

	// outside a sweep the counter never goes down
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_EVAL) |=> (cnt_q >= $past(cnt_q)))
		else $error("replacement counter went down");

	// a replacement flag on a result only comes with an insert
	a_repl_ins: assert property (@(posedge clk) disable iff (!arst_n)
		(done && was_replaced) |-> ($past(cmd_q) == dpht_pkg::CMD_INSERT))
		else $error("replacement flag outside an insert result");

endmodule

[verif/depth_preferred_hash_table_core_tb.sv]
// Self-checking testbench for depth_preferred_hash_table_core: directed and random words.
module depth_preferred_hash_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// command 3 is not decoded by the block; it reports the counter and touches nothing
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// cycles without any accepted word or done strobe before the run is declared hung;
	// a clear or the post-reset sweep runs over all TABLE_ENTRIES entries with neither
	localparam int STALL_LIMIT = 4 * dpht_pkg::TABLE_ENTRIES;
	localparam int REPORT_MAX  = 10;
	localparam int RANDOM_WORDS = 730;

	typedef struct {
		logic [1:0]       cmd;
		dpht_pkg::entry_t ent;
	} table_word_t;

	typedef struct packed {
		logic [63:0]    key;
		logic           occ;
		logic [31:0]    score;
		logic [7:0]     depth;
		logic [1:0]     kind;
		logic [15:0]    move;
		logic           repl;
		dpht_pkg::cnt_t total;
	} table_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = dpht_pkg::CMD_LOOKUP;
	logic [63:0] key = '0;
	logic [31:0] score = '0;
	logic [7:0]  search_depth = '0;
	logic [1:0]  bound_kind = '0;
	logic [15:0] best_move = '0;
	logic        done;
	logic [63:0] found_key;
	logic        occupied;
	logic [31:0] score_out;
	logic [7:0]  depth_out;
	logic [1:0]  kind_out;
	logic [15:0] move_out;
	logic        was_replaced;
	logic [31:0] replace_total;

	table_word_t      word_q[$];   // words waiting to be sent, front is on the pins
	table_reply_t     reply_q[$];  // predicted replies, oldest first
	// sparse copy of the table; absent means all zero
	dpht_pkg::entry_t shadow_slot[dpht_pkg::idx_t];
	dpht_pkg::cnt_t   swap_count = '0;

	int fail_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	depth_preferred_hash_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.key          (key),
		.score        (score),
		.search_depth (search_depth),
		.bound_kind   (bound_kind),
		.best_move    (best_move),
		.done         (done),
		.found_key    (found_key),
		.occupied     (occupied),
		.score_out    (score_out),
		.depth_out    (depth_out),
		.kind_out     (kind_out),
		.move_out     (move_out),
		.was_replaced (was_replaced),
		.replace_total(replace_total)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one accepted word to the shadow table and return the reply it must produce.
	function automatic table_reply_t apply_word(table_word_t w);
		dpht_pkg::entry_t cur;
		dpht_pkg::idx_t   at;
		logic             take;
		table_reply_t     r;
		r = '0;
		at = w.ent.key[dpht_pkg::IDX_W-1:0];
		cur = shadow_slot.exists(at) ? shadow_slot[at] : '0;
		case (w.cmd)
			dpht_pkg::CMD_INSERT: begin
				// depth-preferred rule: empty slot, foreign key, deeper search,
				// or same depth with a stronger bound wins the slot
				take = (cur.key == '0) || (cur.key != w.ent.key) ||
					(cur.depth < w.ent.depth) ||
					(cur.depth == w.ent.depth && cur.kind < w.ent.kind);
				if (take) begin
					cur = w.ent;
					shadow_slot[at] = cur;
					if (swap_count != '1)
						swap_count = swap_count + 1'b1;
					r.repl = 1'b1;
				end
			end
			dpht_pkg::CMD_CLEAR: begin
				shadow_slot.delete();
				swap_count = '0;
			end
			default: ;
		endcase
		// insert and lookup report the slot as it stands now; a zero key reads as empty
		if ((w.cmd == dpht_pkg::CMD_INSERT || w.cmd == dpht_pkg::CMD_LOOKUP) &&
			cur.key != '0) begin
			r.key   = cur.key;
			r.occ   = 1'b1;
			r.score = cur.score;
			r.depth = cur.depth;
			r.kind  = cur.kind;
			r.move  = cur.move;
		end
		r.total = swap_count;
		return r;
	endfunction

	task automatic queue_word(input logic [1:0] c, input logic [63:0] k, input logic [31:0] s,
		input logic [7:0] d, input logic [1:0] b, input logic [15:0] m);
		table_word_t w;
		w.cmd = c;
		w.ent.key = k;
		w.ent.score = s;
		w.ent.depth = d;
		w.ent.kind = b;
		w.ent.move = m;
		word_q.push_back(w);
	endtask

	// Sender: bursts of random length separated by random gaps; bursts count cycles, not
	// words, so gaps land both while the block is busy and while it is waiting for start.
	always @(negedge clk) begin
		if (arst_n) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					// a quarter of the bursts run straight into the next one
					if ($urandom_range(0, 3) == 0)
						gap_left <= 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left <= $urandom_range(8, 24);
					else
						gap_left <= $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
				if (word_q.size() != 0) begin
					start <= 1'b1;
					command <= word_q[0].cmd;
					key <= word_q[0].ent.key;
					score <= word_q[0].ent.score;
					search_depth <= word_q[0].ent.depth;
					bound_kind <= word_q[0].ent.kind;
					best_move <= word_q[0].ent.move;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each done strobe against the oldest prediction, then records the
	// word accepted at this edge. The order matters: a reply never belongs to a word
	// accepted at the same edge.
	always @(posedge clk) begin
		table_reply_t got;
		table_reply_t want;
		table_word_t  w;
		logic         seen;
		if (arst_n) begin
			seen = 1'b0;
			if (done) begin
				seen = 1'b1;
				got = '{found_key, occupied, score_out, depth_out, kind_out, move_out,
					was_replaced, replace_total};
				if (reply_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < REPORT_MAX)
						$display("%0t: done with no word outstanding", $realtime);
				end else begin
					want = reply_q.pop_front();
					if (got.key !== want.key || got.occ !== want.occ ||
						got.score !== want.score || got.depth !== want.depth ||
						got.kind !== want.kind || got.move !== want.move ||
						got.repl !== want.repl || got.total !== want.total) begin
						fail_count <= fail_count + 1;
						if (fail_count < REPORT_MAX) begin
							$display({"%0t: exp key=%h occ=%b score=%h depth=%0d",
								" kind=%0d move=%h repl=%b total=%0d"},
								$realtime, want.key, want.occ, want.score, want.depth,
								want.kind, want.move, want.repl, want.total);
							$display({"%0t: got key=%h occ=%b score=%h depth=%0d",
								" kind=%0d move=%h repl=%b total=%0d"},
								$realtime, got.key, got.occ, got.score, got.depth,
								got.kind, got.move, got.repl, got.total);
						end
					end
				end
			end
			if (start && !busy) begin
				seen = 1'b1;
				w = word_q.pop_front();
				reply_q.push_back(apply_word(w));
			end
			idle_cycles <= seen ? 0 : idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("depth_preferred_hash_table_core: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		logic [63:0] kt;
		logic [47:0] hi_pool[3];
		logic [15:0] idx_pool[12];
		logic [63:0] k;
		logic [1:0]  c;
		logic [7:0]  d;
		int          pick;

		k1 = '1;
		k2 = 64'h1234_5678_9ABC_0005;
		k3 = 64'hFEDC_BA98_7654_0005;
		kt = 64'h8000_0000_0000_0000;

		// directed: empty slots, zero key, every tie-break of the replacement rule,
		// field extremes, the spare command and a clear in the middle
		queue_word(dpht_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0);
		// replaced, still empty
		queue_word(dpht_pkg::CMD_INSERT, '0, 32'hDEAD_BEEF, 8'd7, 2'd2, 16'h1234);
		queue_word(dpht_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0);
		queue_word(dpht_pkg::CMD_INSERT, k1, '1, 8'd255, 2'd3, '1);
		queue_word(dpht_pkg::CMD_INSERT, k1, '0, 8'd255, 2'd3, '0);   // full tie: kept
		queue_word(dpht_pkg::CMD_LOOKUP, k1, '0, '0, '0, '0);
		queue_word(dpht_pkg::CMD_INSERT, k2, 32'h3F80_0000, 8'd10, 2'd1, 16'h0101);
		// shallower: kept
		queue_word(dpht_pkg::CMD_INSERT, k2, 32'h1111_1111, 8'd9, 2'd3, 16'h0202);
		// weaker bound: kept
		queue_word(dpht_pkg::CMD_INSERT, k2, 32'h2222_2222, 8'd10, 2'd0, 16'h0303);
		// stronger bound
		queue_word(dpht_pkg::CMD_INSERT, k2, 32'h3333_3333, 8'd10, 2'd2, 16'h0404);
		// deeper
		queue_word(dpht_pkg::CMD_INSERT, k2, 32'h4444_4444, 8'd11, 2'd0, 16'h0505);
		// other key evicts
		queue_word(dpht_pkg::CMD_INSERT, k3, 32'h5555_5555, 8'd0, 2'd0, 16'h0606);
		queue_word(dpht_pkg::CMD_LOOKUP, k2, '0, '0, '0, '0);        // returns k3
		queue_word(CMD_SPARE, k3, '1, '1, '1, '1);
		queue_word(dpht_pkg::CMD_INSERT, kt, '0, '0, '0, '0);
		queue_word(dpht_pkg::CMD_INSERT, kt, '1, '0, '0, '1);        // tie at zero: kept
		queue_word(dpht_pkg::CMD_CLEAR, k1, '1, '1, '1, '1);
		queue_word(dpht_pkg::CMD_LOOKUP, k1, '0, '0, '0, '0);
		queue_word(CMD_SPARE, '0, '0, '0, '0, '0);
		queue_word(dpht_pkg::CMD_INSERT, k1, 32'hAAAA_5555, 8'd128, 2'd1, 16'h8000);
		queue_word(dpht_pkg::CMD_LOOKUP, 64'h0000_0000_0000_FFFF, '0, '0, '0, '0);

		// random: keys mostly drawn from a few slots and a few upper halves so that the
		// same key comes back and collisions happen; depths bunch low to force ties
		foreach (hi_pool[i])
			hi_pool[i] = {$urandom(), 16'($urandom_range(0, 16'hFFFF))};
		foreach (idx_pool[i])
			idx_pool[i] = 16'($urandom_range(0, 16'hFFFF));
		idx_pool[0] = '0;
		idx_pool[1] = '1;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(0, 4) == 0)
				k = {$urandom(), $urandom()};
			else
				k = {hi_pool[$urandom_range(0, 2)], idx_pool[$urandom_range(0, 11)]};
			pick = $urandom_range(0, 99);
			if (i == 240 || i == 490)
				c = dpht_pkg::CMD_CLEAR;
			else if (pick < 3)
				c = CMD_SPARE;
			else if (pick < 58)
				c = dpht_pkg::CMD_INSERT;
			else
				c = dpht_pkg::CMD_LOOKUP;
			d = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3)) :
				8'($urandom_range(0, 255));
			queue_word(c, k, $urandom(), d, 2'($urandom_range(0, 3)),
				16'($urandom_range(0, 16'hFFFF)));
		end

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || reply_q.size() != 0)
			@(posedge clk);
		// a stray done strobe would show up well within this wait
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("depth_preferred_hash_table_core: match");
		else
			$display("depth_preferred_hash_table_core: mismatch");
		$finish;
	end

endmodule
